FILE: rtl/p7pu_pkg.sv
// ----------------------------------------------------------------------------
// PKCS7 pad/unpad package
// Shared types, register codes and constants for the padding block.
// ----------------------------------------------------------------------------
package p7pu_pkg;

   localparam int MAX_BLOCK_DEF = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_AW        = 3;

   localparam logic       MODE_PAD      = 1'b0;
   localparam logic       MODE_UNPAD    = 1'b1;
   localparam logic [5:0] BLK_LEN_RESET = 6'd16;

   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_BLOCK = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       pad_error;
   } rsp_type;

   typedef struct packed {
      logic       mode;
      logic [5:0] blk_len;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PASS,
      OP_PASS_END,
      OP_PAD_END,
      OP_HOLD,
      OP_HOLD_END,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
   } cmd_type;

endpackage

FILE: rtl/p7pu_front.sv
// ----------------------------------------------------------------------------
// PKCS7 front end
// Accepts input transfers and classifies each into a command for the queue.
// ----------------------------------------------------------------------------
module p7pu_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  p7pu_pkg::req_type req_data,
   input  p7pu_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              q_push,
   output p7pu_pkg::cmd_type q_cmd
);

   p7pu_pkg::op_type op;

   always_comb begin
      if (!req_data.byte_present && !req_data.last) begin
         op = p7pu_pkg::OP_NONE;
      end else if (cfg.mode == p7pu_pkg::MODE_PAD) begin
         if (req_data.byte_present && req_data.last) begin
            op = p7pu_pkg::OP_PASS_END;
         end else if (req_data.byte_present) begin
            op = p7pu_pkg::OP_PASS;
         end else begin
            op = p7pu_pkg::OP_PAD_END;
         end
      end else begin
         if (req_data.byte_present && req_data.last) begin
            op = p7pu_pkg::OP_HOLD_END;
         end else if (req_data.byte_present) begin
            op = p7pu_pkg::OP_HOLD;
         end else begin
            op = p7pu_pkg::OP_CHECK;
         end
      end
   end

   assign req_stall       = q_full;
   assign q_push          = req_valid && !q_full && (op != p7pu_pkg::OP_NONE);
   assign q_cmd.op        = op;
   assign q_cmd.data_byte = req_data.data_byte;

endmodule

FILE: rtl/p7pu_queue.sv
// ----------------------------------------------------------------------------
// PKCS7 command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module p7pu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  p7pu_pkg::cmd_type push_cmd,
   input  logic              pop,
   output p7pu_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   localparam int DEPTH = p7pu_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   p7pu_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == NW'(DEPTH));
   assign head    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == LAST_PTR) ? '0 : wptr_ff + PW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == LAST_PTR) ? '0 : rptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/p7pu_back.sv
// ----------------------------------------------------------------------------
// PKCS7 back end
// Executes queued commands: passes bytes, emits padding, holds the newest
// block in a ring memory, checks the padding and releases the kept bytes.
// ----------------------------------------------------------------------------
module p7pu_back #(
   parameter int MAX_BLOCK = p7pu_pkg::MAX_BLOCK_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  p7pu_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  p7pu_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output p7pu_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int CW = $clog2(MAX_BLOCK + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_BLOCK - 1);
   localparam logic [CW:0]   RING_N    = (CW + 1)'(MAX_BLOCK);

   typedef enum logic [3:0] {
      S_IDLE,
      S_REL,
      S_PAD,
      S_CHK0,
      S_CHK1,
      S_SCAN,
      S_PREP,
      S_DRAIN,
      S_MARK
   } state_type;

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + AW'(1);
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
      return (a == '0) ? LAST_SLOT : a - AW'(1);
   endfunction

   function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
      logic [CW:0] ax;
      logic [CW:0] bx;
      logic [CW:0] r;
      ax = (CW + 1)'(a);
      bx = (CW + 1)'(b);
      if (ax >= bx) begin
         r = ax - bx;
      end else begin
         r = ax + RING_N - bx;
      end
      return r[AW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [CW-1:0]     held_ff, held_in;
   logic [AW-1:0]     ws_ff, ws_in;
   logic [CW-1:0]     phase_ff, phase_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     sa_ff, sa_in;
   logic [7:0]        nb_ff, nb_in;
   logic              ok_ff, ok_in;
   logic              err_ff, err_in;
   logic [7:0]        cur_byte_ff, cur_byte_in;
   logic              cur_end_ff, cur_end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   p7pu_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]        ring_ff [MAX_BLOCK];
   logic [7:0]        rdata_ff;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;

   logic [CW-1:0]     bs;
   logic [CW-1:0]     phase_next;
   logic [CW-1:0]     keep;
   logic [AW-1:0]     oldest;
   logic              rel_need;
   logic              pad_head;
   logic              out_free;
   logic              emit;
   p7pu_pkg::rsp_type emit_data;

   always_comb begin
      if (cfg.blk_len == '0) begin
         bs = CW'(1);
      end else if (int'(cfg.blk_len) > MAX_BLOCK) begin
         bs = CW'(MAX_BLOCK);
      end else begin
         bs = CW'(cfg.blk_len);
      end
   end

   assign oldest     = slot_back(ws_ff, held_ff);
   assign rel_need   = (held_ff >= bs) && (held_ff != '0);
   assign pad_head   = q_head.op inside {p7pu_pkg::OP_PASS, p7pu_pkg::OP_PASS_END,
                                         p7pu_pkg::OP_PAD_END};
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign phase_next = (phase_ff + CW'(1) == bs) ? '0 : phase_ff + CW'(1);
   assign keep       = ok_ff ? held_ff - CW'(nb_ff) : held_ff;

   always_comb begin
      state_in    = state_ff;
      held_in     = held_ff;
      ws_in       = ws_ff;
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      sa_in       = sa_ff;
      nb_in       = nb_ff;
      ok_in       = ok_ff;
      err_in      = err_ff;
      cur_byte_in = cur_byte_ff;
      cur_end_in  = cur_end_ff;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = ws_ff;
      mem_wdata   = q_head.data_byte;
      mem_re      = 1'b0;
      mem_raddr   = oldest;
      emit        = 1'b0;
      emit_data   = '0;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty && pad_head && (phase_ff >= bs)) begin
               phase_in = phase_ff - bs;
            end else if (!q_empty) begin
               case (q_head.op)
                  p7pu_pkg::OP_PASS, p7pu_pkg::OP_PASS_END: begin
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_data = '{q_head.data_byte, 1'b1, 1'b0, 1'b0};
                        phase_in  = phase_next;
                        q_pop     = 1'b1;
                        if (q_head.op == p7pu_pkg::OP_PASS_END) begin
                           cnt_in   = bs - phase_next;
                           nb_in    = 8'(bs - phase_next);
                           state_in = S_PAD;
                        end
                     end
                  end
                  p7pu_pkg::OP_PAD_END: begin
                     q_pop    = 1'b1;
                     cnt_in   = bs - phase_ff;
                     nb_in    = 8'(bs - phase_ff);
                     state_in = S_PAD;
                  end
                  p7pu_pkg::OP_HOLD, p7pu_pkg::OP_HOLD_END: begin
                     q_pop       = 1'b1;
                     cur_byte_in = q_head.data_byte;
                     cur_end_in  = (q_head.op == p7pu_pkg::OP_HOLD_END);
                     if (rel_need) begin
                        mem_re    = 1'b1;
                        mem_raddr = oldest;
                        held_in   = held_ff - CW'(1);
                        state_in  = S_REL;
                     end else begin
                        mem_we  = 1'b1;
                        ws_in   = slot_inc(ws_ff);
                        held_in = held_ff + CW'(1);
                        if (q_head.op == p7pu_pkg::OP_HOLD_END) begin
                           state_in = S_CHK0;
                        end
                     end
                  end
                  p7pu_pkg::OP_CHECK: begin
                     q_pop    = 1'b1;
                     state_in = S_CHK0;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         S_REL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{rdata_ff, 1'b1, 1'b0, 1'b0};
               if (rel_need) begin
                  mem_re    = 1'b1;
                  mem_raddr = oldest;
                  held_in   = held_ff - CW'(1);
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = cur_byte_ff;
                  ws_in     = slot_inc(ws_ff);
                  held_in   = held_ff + CW'(1);
                  state_in  = cur_end_ff ? S_CHK0 : S_IDLE;
               end
            end
         end
         S_PAD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{nb_ff, 1'b1, (cnt_ff == CW'(1)), 1'b0};
               cnt_in    = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  held_in  = '0;
                  ws_in    = '0;
                  phase_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         S_CHK0: begin
            if (held_ff == '0) begin
               err_in   = 1'b1;
               state_in = S_MARK;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = slot_dec(ws_ff);
               state_in  = S_CHK1;
            end
         end
         S_CHK1: begin
            nb_in = rdata_ff;
            if ((rdata_ff != '0) && (9'(rdata_ff) <= 9'(bs)) &&
                (9'(rdata_ff) <= 9'(held_ff))) begin
               ok_in = 1'b1;
               if (rdata_ff == 8'd1) begin
                  state_in = S_PREP;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = slot_dec(slot_dec(ws_ff));
                  sa_in     = slot_dec(slot_dec(ws_ff));
                  cnt_in    = CW'(rdata_ff) - CW'(1);
                  state_in  = S_SCAN;
               end
            end else begin
               ok_in    = 1'b0;
               state_in = S_PREP;
            end
         end
         S_SCAN: begin
            if (rdata_ff != nb_ff) begin
               ok_in = 1'b0;
            end
            if (cnt_ff == CW'(1)) begin
               state_in = S_PREP;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = slot_dec(sa_ff);
               sa_in     = slot_dec(sa_ff);
               cnt_in    = cnt_ff - CW'(1);
            end
         end
         S_PREP: begin
            err_in = !ok_ff;
            if (keep == '0) begin
               state_in = S_MARK;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = oldest;
               sa_in     = slot_inc(oldest);
               cnt_in    = keep;
               state_in  = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{rdata_ff, 1'b1, (cnt_ff == CW'(1)),
                             (cnt_ff == CW'(1)) && err_ff};
               if (cnt_ff == CW'(1)) begin
                  held_in  = '0;
                  ws_in    = '0;
                  phase_in = '0;
                  state_in = S_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = sa_ff;
                  sa_in     = slot_inc(sa_ff);
                  cnt_in    = cnt_ff - CW'(1);
               end
            end
         end
         S_MARK: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{8'd0, 1'b0, 1'b1, err_ff};
               held_in   = '0;
               ws_in     = '0;
               phase_in  = '0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = emit ? emit_data : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         ws_ff        <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         ws_ff        <= ws_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      sa_ff       <= sa_in;
      nb_ff       <= nb_in;
      ok_ff       <= ok_in;
      err_ff      <= err_in;
      cur_byte_ff <= cur_byte_in;
      cur_end_ff  <= cur_end_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= ring_ff[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/pkcs7_pad_unpad.sv
// ----------------------------------------------------------------------------
// PKCS7 pad and unpad stream block
// Adds or checks and strips PKCS7 padding on a byte stream.
// ----------------------------------------------------------------------------
// The req_ channel carries one byte, a byte flag and an end-of-message flag
// per transfer; the rsp_ channel carries one output byte or an empty end
// marker per transfer, with out_last and pad_error on the final one.
// The csr_ port selects pad or unpad mode and the block size.
// A transfer with a byte or an end flag enters a two-entry queue; the
// back end sends its results through a registered output. In pad mode
// each byte is sent from the idle state, the pad state then sends each
// padding byte, and a bare end marker first passes idle with no output.
// After the block size is lowered mid-message, the next pad-mode transfer
// first waits while idle takes each whole new block off the partial block.
// In unpad mode a byte is written to the ring while it fills; once a full
// block is held, the oldest byte is first read from the ring's single read
// port and sent. The end check reads the last held byte as the count,
// compares the other padding bytes if the count is valid, then sends each
// kept byte or an empty marker. Reset selects pad mode with a block size
// of 16 and empties the queue and the held-byte count; the ring itself
// needs no clearing. Under rsp_stall the output register holds its transfer
// and the back end waits to send; when the queue is full req_stall rises.
// ----------------------------------------------------------------------------
module pkcs7_pad_unpad #(
   parameter int MAX_BLOCK = p7pu_pkg::MAX_BLOCK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  p7pu_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output p7pu_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [p7pu_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic       mode_ff, mode_in;
   logic [5:0] blk_len_ff, blk_len_in;
   logic       csr_write;
   logic       reg_index;

   p7pu_pkg::cfg_type cfg;
   p7pu_pkg::cmd_type q_cmd;
   p7pu_pkg::cmd_type q_head;
   logic              q_push, q_pop, q_empty, q_full;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      mode_in    = mode_ff;
      blk_len_in = blk_len_ff;
      if (csr_write) begin
         case (reg_index)
            p7pu_pkg::REG_MODE:  mode_in    = csr_pwdata[0];
            p7pu_pkg::REG_BLOCK: blk_len_in = csr_pwdata[5:0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         p7pu_pkg::REG_MODE:  csr_prdata = {31'd0, mode_ff};
         p7pu_pkg::REG_BLOCK: csr_prdata = {26'd0, blk_len_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= p7pu_pkg::MODE_PAD;
         blk_len_ff <= p7pu_pkg::BLK_LEN_RESET;
      end else begin
         mode_ff    <= mode_in;
         blk_len_ff <= blk_len_in;
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.blk_len = blk_len_ff;

   p7pu_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   p7pu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   p7pu_back #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: bench/tb_pkcs7_pad_unpad.sv
// ----------------------------------------------------------------------------
// PKCS7 pad and unpad block testbench
// Streams messages through the block in both modes and across block sizes,
// predicts every output transfer in a behavioral model and compares each
// one, field by field, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_pkcs7_pad_unpad;

   localparam int MB       = p7pu_pkg::MAX_BLOCK_DEF;
   localparam int QUIET    = 100;
   localparam int WATCHDOG = 5000;

   typedef logic [7:0] byte_q_type [$];
   typedef enum {NO_END, END_WITH_BYTE, END_BARE} end_kind_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   p7pu_pkg::req_type             req_data    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   p7pu_pkg::rsp_type             rsp_data;
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [p7pu_pkg::CSR_AW-1:0]   csr_paddr   = '0;
   logic [31:0]                   csr_pwdata  = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   logic [7:0]          ring_m [MB];
   int                  held_n  = 0;
   int                  slot_w  = 0;
   int                  phase_n = 0;
   logic                mode_m  = p7pu_pkg::MODE_PAD;
   logic [5:0]          bsize_m = p7pu_pkg::BLK_LEN_RESET;
   p7pu_pkg::rsp_type   due_rsp [$];

   int                  mismatches   = 0;
   int                  items_sent   = 0;
   int                  quiet_cycles = 0;
   int                  idle_pct     = 0;
   int                  stall_pct    = 0;
   int                  noise_pct    = 0;
   int                  mid_cfg_pct  = 0;

   pkcs7_pad_unpad uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int eff_size();
      if (bsize_m == 6'd0) return 1;
      if (int'(bsize_m) > MB) return MB;
      return int'(bsize_m);
   endfunction

   task automatic add_rsp(input logic [7:0] b, input logic v, input logic l, input logic e);
      p7pu_pkg::rsp_type r;
      r.out_byte  = b;
      r.out_valid = v;
      r.out_last  = l;
      r.pad_error = e;
      due_rsp.push_back(r);
   endtask

   task automatic pkcs7_step(input p7pu_pkg::req_type item);
      int  bs;
      int  pad;
      int  keep;
      int  start;
      int  nb;
      bit  good;
      bs = eff_size();
      if (mode_m == p7pu_pkg::MODE_PAD) begin
         if (item.byte_present) begin
            add_rsp(item.data_byte, 1'b1, 1'b0, 1'b0);
            phase_n = (phase_n + 1) % bs;
         end
         if (item.last) begin
            pad = bs - (phase_n % bs);
            for (int i = 0; i < pad; i++)
               add_rsp(8'(pad), 1'b1, (i + 1 == pad), 1'b0);
            held_n  = 0;
            slot_w  = 0;
            phase_n = 0;
         end
      end else begin
         if (item.byte_present) begin
            while (held_n >= bs && held_n > 0) begin
               add_rsp(ring_m[(slot_w + MB - held_n) % MB], 1'b1, 1'b0, 1'b0);
               held_n--;
            end
            ring_m[slot_w] = item.data_byte;
            slot_w = (slot_w + 1) % MB;
            held_n++;
         end
         if (item.last) begin
            good = 1'b0;
            keep = held_n;
            if (held_n > 0) begin
               nb = int'(ring_m[(slot_w + MB - 1) % MB]);
               if (nb >= 1 && nb <= bs && nb <= held_n) begin
                  good = 1'b1;
                  for (int i = 1; i <= nb; i++)
                     if (int'(ring_m[(slot_w + MB - i) % MB]) != nb) good = 1'b0;
               end
               if (good) keep = held_n - nb;
            end
            start = (slot_w + MB - held_n) % MB;
            if (keep == 0) begin
               add_rsp(8'h00, 1'b0, 1'b1, !good);
            end else begin
               for (int i = 0; i < keep; i++)
                  add_rsp(ring_m[(start + i) % MB], 1'b1, (i + 1 == keep),
                          (i + 1 == keep) && !good);
            end
            held_n  = 0;
            slot_w  = 0;
            phase_n = 0;
         end
      end
   endtask

   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      p7pu_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp.size() == 0) begin
            note_failure($sformatf("expected none, got byte %02h valid %0b last %0b err %0b",
                                   rsp_data.out_byte, rsp_data.out_valid,
                                   rsp_data.out_last, rsp_data.pad_error));
         end else begin
            want = due_rsp.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.out_valid !== want.out_valid
                || rsp_data.out_last !== want.out_last
                || rsp_data.pad_error !== want.pad_error) begin
               note_failure($sformatf(
                  "expected byte %02h valid %0b last %0b err %0b, got %02h %0b %0b %0b",
                  want.out_byte, want.out_valid, want.out_last, want.pad_error,
                  rsp_data.out_byte, rsp_data.out_valid, rsp_data.out_last,
                  rsp_data.pad_error));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("tb_pkcs7_pad_unpad: FAIL");
            $finish;
         end
      end
   end

   task automatic settle();
      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (QUIET) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      settle();
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_idx == p7pu_pkg::REG_MODE) mode_m = value[0];
      else bsize_m = value[5:0];
   endtask

   task automatic random_config();
      logic [31:0] value;
      value = $urandom;
      if ($urandom_range(1) == 0) begin
         csr_write(p7pu_pkg::REG_MODE, value);
      end else begin
         case ($urandom_range(19))
            0: begin
               value[5:0] = 6'd0;
            end
            1: begin
               value[5:0] = 6'd32;
            end
            2: begin
               value[5:0] = 6'($urandom_range(63, 33));
            end
            3: begin
               value[5:0] = p7pu_pkg::BLK_LEN_RESET;
            end
            default: begin
               value[5:0] = 6'($urandom_range(8, 1));
            end
         endcase
         csr_write(p7pu_pkg::REG_BLOCK, value);
      end
   endtask

   task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
      p7pu_pkg::req_type item;
      item.data_byte    = data;
      item.byte_present = present;
      item.last         = fin;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pkcs7_step(item);
      items_sent++;
   endtask

   task automatic send_bytes(input byte_q_type msg, input end_kind_type ending);
      for (int i = 0; i < msg.size(); i++) begin
         if ($urandom_range(99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
         if ($urandom_range(99) < mid_cfg_pct) random_config();
         send_item(msg[i], 1'b1, ending == END_WITH_BYTE && i == msg.size() - 1);
      end
      if (ending == END_BARE || (ending == END_WITH_BYTE && msg.size() == 0))
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic test_pad_directed();
      byte_q_type msg;
      msg = '{8'h00, 8'hFF};
      send_bytes(msg, END_WITH_BYTE);
      msg.delete();
      send_bytes(msg, END_BARE);
      send_item(8'h5C, 1'b0, 1'b0);
      msg = '{8'hA5};
      send_bytes(msg, END_WITH_BYTE);
      csr_write(p7pu_pkg::REG_BLOCK, 32'd0);
      msg.delete();
      send_bytes(msg, END_BARE);
      csr_write(p7pu_pkg::REG_BLOCK, 32'd63);
      msg = '{8'h11};
      send_bytes(msg, END_WITH_BYTE);
      csr_write(p7pu_pkg::REG_BLOCK, 32'd1);
      msg = '{8'h22, 8'h33};
      send_bytes(msg, END_BARE);
   endtask

   task automatic test_unpad_directed();
      byte_q_type msg;
      csr_write(p7pu_pkg::REG_MODE, 32'(p7pu_pkg::MODE_UNPAD));
      csr_write(p7pu_pkg::REG_BLOCK, 32'd2);
      msg = '{8'hFF, 8'h41, 8'h01};
      send_bytes(msg, END_WITH_BYTE);
      msg.delete();
      send_bytes(msg, END_BARE);
      msg = '{8'h02, 8'h02};
      send_bytes(msg, END_BARE);
      msg = '{8'hFF};
      send_bytes(msg, END_WITH_BYTE);
      msg = '{8'h00};
      send_bytes(msg, END_WITH_BYTE);
      msg = '{8'h01, 8'h02};
      send_bytes(msg, END_WITH_BYTE);
      msg = '{8'h02};
      send_bytes(msg, END_WITH_BYTE);
   endtask

   task automatic test_midmessage_changes();
      byte_q_type msg;
      csr_write(p7pu_pkg::REG_BLOCK, 32'd4);
      msg = '{8'h10, 8'h11, 8'h12};
      send_bytes(msg, NO_END);
      csr_write(p7pu_pkg::REG_BLOCK, 32'd2);
      msg = '{8'h13};
      send_bytes(msg, END_WITH_BYTE);
      csr_write(p7pu_pkg::REG_BLOCK, 32'd4);
      msg = '{8'h07, 8'h08};
      send_bytes(msg, NO_END);
      csr_write(p7pu_pkg::REG_MODE, 32'(p7pu_pkg::MODE_PAD));
      msg = '{8'h09};
      send_bytes(msg, END_WITH_BYTE);
      csr_write(p7pu_pkg::REG_BLOCK, 32'd8);
      msg = '{8'h01, 8'h02, 8'h03};
      send_bytes(msg, NO_END);
      csr_write(p7pu_pkg::REG_BLOCK, 32'd2);
      msg.delete();
      send_bytes(msg, END_BARE);
      msg = '{8'h01};
      send_bytes(msg, NO_END);
      csr_write(p7pu_pkg::REG_MODE, 32'(p7pu_pkg::MODE_UNPAD));
      send_bytes(msg, END_WITH_BYTE);
   endtask

   task automatic test_random_stream();
      int           idle_set  [4] = '{0, 53, 0, 33};
      int           stall_set [4] = '{0, 0, 53, 33};
      byte_q_type   msg;
      int           bs;
      int           len;
      int           n;
      int           kind;
      end_kind_type ending;
      noise_pct   = 8;
      mid_cfg_pct = 2;
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_set[p];
         stall_pct = stall_set[p];
         random_config();
         random_config();
         items_sent = 0;
         while (items_sent < 75) begin
            if ($urandom_range(9) == 0) random_config();
            if ($urandom_range(14) == 0) settle();
            bs = eff_size();
            msg.delete();
            if (mode_m == p7pu_pkg::MODE_PAD) begin
               len = $urandom_range((2 * bs + 1 > 40) ? 40 : 2 * bs + 1, 0);
               repeat (len) msg.push_back(8'($urandom));
            end else begin
               len = $urandom_range(bs + 3, 0);
               repeat (len) msg.push_back(8'($urandom));
               kind = $urandom_range(9);
               if (kind <= 7) begin
                  n = bs - len % bs;
                  repeat (n) msg.push_back(8'(n));
                  if (kind == 7) msg[$urandom_range(msg.size() - 1, len)] = 8'($urandom);
               end else if (kind == 8) begin
                  msg.push_back(($urandom_range(1) == 0) ? 8'h00
                                : 8'($urandom_range(255, bs + 1)));
               end
            end
            ending = ($urandom_range(4) == 0) ? END_BARE : END_WITH_BYTE;
            send_bytes(msg, ending);
         end
      end
      noise_pct   = 0;
      mid_cfg_pct = 0;
      idle_pct    = 0;
      stall_pct   = 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pad_directed();
      test_unpad_directed();
      test_midmessage_changes();
      test_random_stream();
      settle();
      if (mismatches == 0 && due_rsp.size() == 0) begin
         $display("tb_pkcs7_pad_unpad: PASS");
      end else begin
         $display("tb_pkcs7_pad_unpad: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/p7pu_pkg.sv
rtl/p7pu_front.sv
rtl/p7pu_queue.sv
rtl/p7pu_back.sv
rtl/pkcs7_pad_unpad.sv
bench/tb_pkcs7_pad_unpad.sv
